// ===== sv/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

   // Largest length handled is 2^LENGTH_WIDTH - 1 (range 16..32).
   localparam int unsigned LENGTH_WIDTH = 32;
   localparam logic [31:0] MAX_LENGTH   = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

   // Short header length that escapes to a 4-byte long length.
   localparam logic [15:0] ESCAPE_LEN   = 16'hFFFF;
   localparam logic [2:0]  LONG_BYTES   = 3'd4;

   // Deframer phase codes; the unused code behaves as PH_SHORT.
   localparam logic [1:0]  PH_SHORT     = 2'd0;
   localparam logic [1:0]  PH_LONG      = 2'd1;
   localparam logic [1:0]  PH_PAYLOAD   = 2'd2;

   typedef struct packed {
      logic        is_payload;
      logic [7:0]  payload_byte;
      logic [31:0] frame_length;
      logic [31:0] bytes_wanted;
      logic        frame_end;
   } lpd_result_type;

endpackage

`default_nettype wire

// ===== sv/length_prefix_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a received byte stream into length-prefixed frames.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser      | tlast
//  req     | in  | data_byte[7:0]                            | -          | -
//  rsp     | out | payload_byte[7:0], frame_length[31:0],    | is_payload | frame_end
//          |     | bytes_wanted[31:0]                        |            |
//
//  One byte per cycle sustained while rsp_tready stays high; each beat gives exactly one result beat.
//  The path is registered twice: input register, then decode into the result register.
//  The decode is a single pass of the frame state plus one 32-bit decrement.
//  Reset returns to waiting for a short header with all counters cleared.
//  A stalled rsp side holds the result register and backs up into the input
//  register; req_tready drops only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer_core import lpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata,   // [7:0] payload_byte, [39:8] frame_length,
                                         // [71:40] bytes_wanted
   output      logic        rsp_tuser,   // [0] is_payload
   output      logic        rsp_tlast    // frame_end
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff,  in_byte_in;
   logic           out_valid_ff, out_valid_in;
   lpd_result_type out_ff, out_in;
   logic           advance;
   lpd_result_type decoded;

   // Move the held byte into the result register when that slot frees up.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   lpd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (decoded)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = decoded;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;   // drop the delivered beat
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.bytes_wanted, out_ff.frame_length, out_ff.payload_byte};
   assign rsp_tuser  = out_ff.is_payload;
   assign rsp_tlast  = out_ff.frame_end;

endmodule

`default_nettype wire

// ===== sv/lpd_decode.sv =====
// ----------------------------------------------------------------------------
// lpd_decode
// Frame state and per-byte decode: header assembly, escape, payload count.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_decode import lpd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,       // consume data_byte this cycle
   input  wire logic [7:0]     data_byte,
   output lpd_result_type      result
);

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] left_ff,  left_in;

   logic [31:0] long_asm;
   logic [2:0]  count_inc;
   logic [15:0] short_len;
   logic [31:0] hdr_len;
   logic        hdr_done;
   logic [31:0] len_sat;
   logic [31:0] left_dec;

   always_comb begin
      long_asm  = (count_ff == 3'd0) ? {24'd0, data_byte} : {shift_ff[23:0], data_byte};
      count_inc = count_ff + 3'd1;
      short_len = {shift_ff[7:0], data_byte};
      left_dec  = (left_ff != 32'd0) ? left_ff - 32'd1 : 32'd0;

      phase_in = phase_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      result   = '0;
      hdr_done = 1'b0;
      hdr_len  = 32'd0;

      case (phase_ff)
         PH_LONG: begin
            shift_in = long_asm;
            count_in = count_inc;
            if (count_inc >= LONG_BYTES || count_inc == 3'd0) begin
               hdr_done = 1'b1;
               hdr_len  = long_asm;
            end else begin
               result.bytes_wanted = 32'(LONG_BYTES - count_inc);
            end
         end
         PH_PAYLOAD: begin
            result.is_payload   = 1'b1;
            result.payload_byte = data_byte;
            result.frame_length = shift_ff;
            result.bytes_wanted = left_dec;
            left_in             = left_dec;
            if (left_dec == 32'd0) begin
               result.frame_end = 1'b1;
               phase_in         = PH_SHORT;
               count_in         = 3'd0;
            end
         end
         default: begin
            phase_in = PH_SHORT;
            if (count_ff == 3'd0) begin
               shift_in            = {24'd0, data_byte};
               count_in            = 3'd1;
               result.bytes_wanted = 32'd1;
            end else begin
               count_in = 3'd0;
               if (short_len == ESCAPE_LEN) begin
                  phase_in            = PH_LONG;
                  shift_in            = 32'd0;
                  result.bytes_wanted = 32'(LONG_BYTES);
               end else begin
                  hdr_done = 1'b1;
                  hdr_len  = {16'd0, short_len};
               end
            end
         end
      endcase

      // Header complete: clamp, then enter payload or close an empty frame.
      len_sat = (hdr_len > MAX_LENGTH) ? MAX_LENGTH : hdr_len;
      if (hdr_done) begin
         shift_in            = len_sat;
         count_in            = 3'd0;
         result.frame_length = len_sat;
         left_in             = len_sat;
         result.bytes_wanted = len_sat;
         if (len_sat == 32'd0) begin
            result.frame_end = 1'b1;
            phase_in         = PH_SHORT;
         end else begin
            phase_in         = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SHORT;
         count_ff <= 3'd0;
         shift_ff <= 32'd0;
         left_ff  <= 32'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for length_prefix_deframer_core. Bytes are pushed in as
// whole frames (short header, escaped long header, empty frames, runs of
// payload), and every rsp beat is checked against a cycle-free model of the
// frame decoder. The sender works in bursts with gaps, and the receiver
// stalls in changing patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import lpd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks the frame state of the deframer and holds the beats it must emit.
   class deframe_scoreboard;
      logic [1:0]     phase      = PH_SHORT;
      logic [2:0]     hdr_taken  = '0;
      logic [31:0]    len_acc    = '0;
      logic [31:0]    pay_left   = '0;
      lpd_result_type decoded_q[$];
      int unsigned    errors     = 0;

      // Header done: clamp the length, then open the payload or close an empty frame.
      function void close_header(input logic [31:0] len, inout lpd_result_type r);
         if (len > MAX_LENGTH)
            len = MAX_LENGTH;
         len_acc        = len;
         hdr_taken      = '0;
         r.frame_length = len;
         if (len == '0) begin
            r.frame_end  = 1'b1;
            r.bytes_wanted = '0;
            phase        = PH_SHORT;
            pay_left     = '0;
         end else begin
            r.bytes_wanted = len;
            phase        = PH_PAYLOAD;
            pay_left     = len;
         end
      endfunction

      // Advance the frame state by one accepted byte and queue the beat it causes.
      function void decode_byte(input logic [7:0] b);
         lpd_result_type r;
         logic [15:0]    short_len;
         r = '0;
         case (phase)
            PH_LONG: begin
               if (hdr_taken == '0)
                  len_acc = {24'd0, b};
               else
                  len_acc = {len_acc[23:0], b};
               hdr_taken = hdr_taken + 3'd1;
               if (hdr_taken >= LONG_BYTES || hdr_taken == '0)
                  close_header(len_acc, r);
               else
                  r.bytes_wanted = 32'(LONG_BYTES) - 32'(hdr_taken);
            end
            PH_PAYLOAD: begin
               r.is_payload   = 1'b1;
               r.payload_byte = b;
               r.frame_length = len_acc;
               if (pay_left != '0)
                  pay_left = pay_left - 32'd1;
               r.bytes_wanted = pay_left;
               if (pay_left == '0) begin
                  r.frame_end = 1'b1;
                  phase       = PH_SHORT;
                  hdr_taken   = '0;
               end
            end
            default: begin
               // the unused phase code acts as the short header phase
               phase = PH_SHORT;
               if (hdr_taken == '0) begin
                  len_acc        = {24'd0, b};
                  hdr_taken      = 3'd1;
                  r.bytes_wanted = 32'd1;
               end else begin
                  short_len = {len_acc[7:0], b};
                  hdr_taken = '0;
                  if (short_len == ESCAPE_LEN) begin
                     phase          = PH_LONG;
                     len_acc        = '0;
                     r.bytes_wanted = 32'(LONG_BYTES);
                  end else begin
                     close_header({16'd0, short_len}, r);
                  end
               end
            end
         endcase
         decoded_q.insert(decoded_q.size(), r);
      endfunction

      function void match_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $realtime, field,
                     want, got);
         end
      endfunction

      function void check_beat(input logic [71:0] tdata, input logic tuser,
                               input logic tlast);
         lpd_result_type want;
         if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected rsp beat, expected none actual %h/%b/%b",
                     $realtime, tdata, tuser, tlast);
            return;
         end
         want = decoded_q[0];
         decoded_q.delete(0);
         match_field("is_payload",   32'(want.is_payload),   32'(tuser));
         match_field("payload_byte", 32'(want.payload_byte), 32'(tdata[7:0]));
         match_field("frame_length", want.frame_length,      tdata[39:8]);
         match_field("bytes_wanted", want.bytes_wanted,      tdata[71:40]);
         match_field("frame_end",    32'(want.frame_end),    32'(tlast));
      endfunction

      function int unsigned pending();
         return decoded_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;      // [7:0] payload_byte, [39:8] frame_length, [71:40] bytes_wanted
   logic        rsp_tuser;      // [0] is_payload
   logic        rsp_tlast;      // frame_end

   deframe_scoreboard sb = new();

   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned rx_mode    = 0;
   int unsigned mode_left  = 0;

   length_prefix_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Receiver: switch between always ready, coin-flip ready and long stalls.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = $urandom_range(0, 2);
         mode_left = $urandom_range(40, 300);
      end else begin
         mode_left = mode_left - 1;
      end
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Check every rsp beat against the oldest decoded expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Drive one byte in; start a new burst, after a random gap, when one runs out.
   // Entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.decode_byte(b);
      burst_left--;
      bytes_sent++;
      @(negedge clock);
   endtask

   // Emit a frame header: two bytes, or the escape followed by four length bytes.
   task automatic send_header(input logic [31:0] len, input bit long_form);
      if (long_form) begin
         send_byte(8'hFF);
         send_byte(8'hFF);
         send_byte(len[31:24]);
         send_byte(len[23:16]);
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else begin
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end
   endtask

   task automatic send_payload(input int unsigned n);
      repeat (n) send_byte(8'($urandom));
   endtask

   // Hold the sender off until every queued beat has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      int unsigned pick;
      logic [31:0] len;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty frame, tiny frames with extreme payload bytes,
      // escape to a zero long length, escape to a short long length.
      send_header(32'd0, 1'b0);
      send_header(32'd1, 1'b0);
      send_byte(8'h00);
      send_header(32'd2, 1'b0);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_header(32'd0, 1'b1);
      send_header(32'd3, 1'b1);
      send_byte(8'h5A);
      send_byte(8'h00);
      send_byte(8'hFF);
      drain();

      // Random: mostly well-formed frames with random payload.
      while (bytes_sent < 720) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = $urandom_range(1, 12);
            send_header(len, 1'b0);
         end else if (pick < 72) begin
            len = $urandom_range(0, 12);
            send_header(len, 1'b1);
         end else if (pick < 84) begin
            len = $urandom_range(13, 300);
            send_header(len, 1'b0);
         end else begin
            len = '0;
            send_header(len, 1'($urandom_range(0, 1)));
         end
         send_payload(len);
         if ($urandom_range(0, 99) < 3)
            drain();
      end

      // Last: the largest long length, never finished; the block stays in payload.
      send_header(32'hFFFF_FFFF, 1'b1);
      send_payload(6);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run (~1030 beats, long gaps and stalls).
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
